[rtl/core/sha256_stream_hasher_macros.svh]
// Assertion macros for the SHA-256 stream hasher checker.
// Included by files that write concurrent assertions; defines nothing else.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SHS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("SHS assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("SHS assertion failed");

`endif

[rtl/core/shs_pkg.sv]
// Shared types, constants and functions of the SHA-256 stream hasher.
// No dependencies; imported by shs_msg_sched, shs_round_core and sha256_stream_hasher.
`default_nettype none

package shs_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned CHAIN_WORDS = 8;
    localparam int unsigned SCHED_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [5:0] LAST_SLOT     = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;

    localparam t_word HASH_IV [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef struct packed {
        logic load;
        logic step;
        logic fold;
        logic init;
    } t_rnd_ctrl;

    typedef struct packed {
        logic       shift;
        logic       step;
        logic [7:0] data;
    } t_sch_ctrl;

    function automatic t_word rotr(t_word x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

[rtl/core/shs_stream_if.sv]
// Valid/ready channel interfaces of the SHA-256 stream hasher.
// Byte input channel and digest output channel; no dependencies.
`default_nettype none

interface shs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;

    modport source (output valid, output data_byte, output byte_valid,
                    output last_byte, input ready);
    modport sink (input valid, input data_byte, input byte_valid,
                  input last_byte, output ready);
endinterface

interface shs_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_words_0_1;
    logic [63:0] digest_words_2_3;
    logic [63:0] digest_words_4_5;
    logic [63:0] digest_words_6_7;

    modport source (output valid, output digest_words_0_1, output digest_words_2_3,
                    output digest_words_4_5, output digest_words_6_7, input ready);
    modport sink (input valid, input digest_words_0_1, input digest_words_2_3,
                  input digest_words_4_5, input digest_words_6_7, output ready);
endinterface

`default_nettype wire

[rtl/core/shs_msg_sched.sv]
// Block buffer and message schedule window of the SHA-256 stream hasher.
// Depends on shs_pkg.
`default_nettype none

module shs_msg_sched (
    input  logic              i_clk,
    input  shs_pkg::t_sch_ctrl i_ctrl,
    output shs_pkg::t_word    o_word
);
    import shs_pkg::*;

    t_word r_w [SCHED_WORDS];
    t_word n_w [SCHED_WORDS];
    t_word w_new;

    assign w_new  = r_w[0] + small_sigma0(r_w[1]) + r_w[9] + small_sigma1(r_w[14]);
    assign o_word = r_w[0];

    always_comb begin
        for (int i = 0; i < SCHED_WORDS; i++) begin
            n_w[i] = r_w[i];
        end
        if (i_ctrl.shift) begin
            for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                n_w[i] = {r_w[i][23:0], r_w[i+1][31:24]};
            end
            n_w[SCHED_WORDS-1] = {r_w[SCHED_WORDS-1][23:0], i_ctrl.data};
        end else if (i_ctrl.step) begin
            for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                n_w[i] = r_w[i+1];
            end
            n_w[SCHED_WORDS-1] = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SCHED_WORDS; i++) begin
            r_w[i] <= n_w[i];
        end
    end

endmodule

`default_nettype wire

[rtl/core/shs_round_core.sv]
// Chain value and shared compression round unit of the SHA-256 stream hasher.
// Depends on shs_pkg.
`default_nettype none

module shs_round_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shs_pkg::t_rnd_ctrl i_ctrl,
    input  shs_pkg::t_word    i_k,
    input  shs_pkg::t_word    i_w,
    output logic [255:0]      o_chain
);
    import shs_pkg::*;

    t_word r_chain [CHAIN_WORDS];
    t_word r_v     [CHAIN_WORDS];
    t_word t1;
    t_word t2;

    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + i_k + i_w;
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    for (genvar g = 0; g < CHAIN_WORDS; g++) begin : g_out
        assign o_chain[255 - 32*g -: 32] = r_chain[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_chain[i] <= HASH_IV[i];
            end
        end else if (i_ctrl.init) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_chain[i] <= HASH_IV[i];
            end
        end else if (i_ctrl.fold) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_chain[i] <= r_chain[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (i_ctrl.step) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

endmodule

`default_nettype wire

[rtl/core/sha256_stream_hasher.sv]
// SHA-256 stream hasher top level: sequencer, byte counter and digest register.
// Depends on shs_pkg, shs_stream_if, shs_msg_sched and shs_round_core.
//
// A byte transaction is taken while the block is idle. Every 64th message byte
// starts a compression on the single shared round unit: the round steps, then a
// fold of the result into the chain value, with ready low throughout. A
// transaction with last_byte set is followed by the padding bytes, written one
// per cycle outside the compressions, one or two compressions, and a move of
// the digest into the output register once it is free. The output register lets
// the next message start while an earlier digest still waits to be taken.
`default_nettype none

module sha256_stream_hasher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    shs_byte_if.sink            i_byte,
    shs_digest_if.source        o_digest
);
    import shs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_FOLD  = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [5:0]   r_fill, n_fill;
    logic [5:0]   r_round, n_round;
    logic [60:0]  r_bytes, n_bytes;
    logic         r_finish, n_finish;
    logic         r_mark_sent, n_mark_sent;
    logic         r_len_act, n_len_act;
    logic         r_out_valid, n_out_valid;
    logic [255:0] r_out_data;
    logic         out_load;
    logic         in_accept;
    logic [7:0]   pad_byte;
    logic         pad_len;
    logic [255:0] chain;
    t_word        sched_word;
    t_rnd_ctrl    rnd_ctrl;
    t_sch_ctrl    sch_ctrl;

    assign i_byte.ready = (r_state == S_IDLE);
    assign in_accept    = i_byte.valid & i_byte.ready;

    assign pad_len  = r_len_act | (r_fill == LEN_FIELD_POS);
    assign pad_byte = !r_mark_sent ? PAD_MARK : (pad_len ? r_bytes[60:53] : 8'h00);

    shs_msg_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (sch_ctrl),
        .o_word (sched_word)
    );

    shs_round_core u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (rnd_ctrl),
        .i_k     (ROUND_K[r_round]),
        .i_w     (sched_word),
        .o_chain (chain)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_round     = r_round;
        n_bytes     = r_bytes;
        n_finish    = r_finish;
        n_mark_sent = r_mark_sent;
        n_len_act   = r_len_act;
        n_out_valid = r_out_valid & ~o_digest.ready;
        out_load    = 1'b0;
        rnd_ctrl    = '0;
        sch_ctrl    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_finish = i_byte.last_byte;
                    if (i_byte.byte_valid) begin
                        sch_ctrl.shift = 1'b1;
                        sch_ctrl.data  = i_byte.data_byte;
                        n_fill         = r_fill + 6'd1;
                        n_bytes        = r_bytes + 61'd1;
                    end
                    if (i_byte.byte_valid && r_fill == LAST_SLOT) begin
                        rnd_ctrl.load = 1'b1;
                        n_round       = '0;
                        n_state       = S_ROUND;
                    end else if (i_byte.last_byte) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                rnd_ctrl.step = 1'b1;
                sch_ctrl.step = 1'b1;
                n_round       = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                rnd_ctrl.fold = 1'b1;
                if (r_len_act) begin
                    n_state = S_OUT;
                end else if (r_finish) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                sch_ctrl.shift = 1'b1;
                sch_ctrl.data  = pad_byte;
                n_fill         = r_fill + 6'd1;
                if (!r_mark_sent) begin
                    n_mark_sent = 1'b1;
                end else if (pad_len) begin
                    n_len_act = 1'b1;
                    n_bytes   = r_bytes << 8;
                end
                if (r_fill == LAST_SLOT) begin
                    rnd_ctrl.load = 1'b1;
                    n_round       = '0;
                    n_state       = S_ROUND;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_digest.ready) begin
                    out_load      = 1'b1;
                    n_out_valid   = 1'b1;
                    rnd_ctrl.init = 1'b1;
                    n_bytes       = '0;
                    n_finish      = 1'b0;
                    n_mark_sent   = 1'b0;
                    n_len_act     = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_round     <= '0;
            r_bytes     <= '0;
            r_finish    <= 1'b0;
            r_mark_sent <= 1'b0;
            r_len_act   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_round     <= n_round;
            r_bytes     <= n_bytes;
            r_finish    <= n_finish;
            r_mark_sent <= n_mark_sent;
            r_len_act   <= n_len_act;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= chain;
        end
    end

    assign o_digest.valid            = r_out_valid;
    assign o_digest.digest_words_0_1 = r_out_data[255:192];
    assign o_digest.digest_words_2_3 = r_out_data[191:128];
    assign o_digest.digest_words_4_5 = r_out_data[127:64];
    assign o_digest.digest_words_6_7 = r_out_data[63:0];

endmodule

`default_nettype wire

[rtl/core/shs_checker.sv]
// Port-level assertions for the SHA-256 stream hasher, bound to its top level.
// Depends on sha256_stream_hasher_macros.svh and sha256_stream_hasher.
`default_nettype none

`include "sha256_stream_hasher_macros.svh"

module shs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_in_byte_valid,
    input logic         i_in_last,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [255:0] i_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid & i_in_ready;

    // A digest waiting to be taken stays put.
    `SHS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // The end of a message starts padding or a compression, so the input closes at once.
    `SHS_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, in_acc && i_in_last, !i_in_ready)

    // Finishing a message takes at least one full compression.
    `SHS_ASSERT_SAME(a_long_finish, i_clk, i_rst_n, in_acc && i_in_last, ##64 !i_in_ready)

    // A transaction that carries neither a byte nor the end leaves the block idle.
    `SHS_ASSERT_NEXT(a_empty_item_idle, i_clk, i_rst_n, in_acc && !i_in_byte_valid && !i_in_last, i_in_ready)

    // A new digest only appears after the block has been busy finishing.
    `SHS_ASSERT_SAME(a_digest_after_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_byte.valid),
    .i_in_ready      (i_byte.ready),
    .i_in_byte_valid (i_byte.byte_valid),
    .i_in_last       (i_byte.last_byte),
    .i_out_valid     (o_digest.valid),
    .i_out_ready     (o_digest.ready),
    .i_out_data      ({o_digest.digest_words_0_1, o_digest.digest_words_2_3,
                       o_digest.digest_words_4_5, o_digest.digest_words_6_7})
);

`default_nettype wire

[tb/shs_digest_checker.sv]
// Checker for the SHA-256 stream hasher: watches the byte and digest channels.
// Predicts every digest with its own SHA-256 model and compares it in 64-bit pairs of words.
// Depends on the shs_byte_if and shs_digest_if interfaces.
`default_nettype none

module shs_digest_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    shs_byte_if          i_byte,
    shs_digest_if        i_digest,
    output int           o_fail_count,
    output int           o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [31:0]  hash_state [8];
    logic [7:0]   block_bytes [64];
    logic [5:0]   bytes_held;
    logic [63:0]  length_bits;
    logic [255:0] expected_digests [$];
    int           mismatch_count;

    function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
        logic [63:0] doubled;
        doubled = {x, x} >> n;
        return doubled[31:0];
    endfunction

    function automatic void reset_hash();
        int i;
        for (i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
        for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
        bytes_held = '0;
        length_bits = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        int t;
        for (t = 0; t < 16; t++) begin
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                    block_bytes[4*t+3]};
        end
        for (t = 16; t < 64; t++) begin
            w[t] = w[t-16] + w[t-7]
                 + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
        end
        for (t = 0; t < 8; t++) v[t] = hash_state[t];
        for (t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (t = 0; t < 8; t++) hash_state[t] = hash_state[t] + v[t];
    endfunction

    function automatic logic [255:0] close_message();
        int pos;
        int j;
        logic [255:0] digest;
        pos = bytes_held;
        block_bytes[pos] = 8'h80;
        pos++;
        if (pos > 56) begin
            for (j = pos; j < 64; j++) block_bytes[j] = 8'h00;
            compress_block();
            pos = 0;
        end
        for (j = pos; j < 56; j++) block_bytes[j] = 8'h00;
        for (j = 0; j < 8; j++) block_bytes[56+j] = length_bits[63-8*j -: 8];
        compress_block();
        for (j = 0; j < 8; j++) digest[255-32*j -: 32] = hash_state[j];
        reset_hash();
        return digest;
    endfunction

    always @(posedge i_clk) begin
        logic [255:0] want;
        logic [255:0] got;
        int j;
        if (!i_rst_n) begin
            reset_hash();
            expected_digests.delete();
            mismatch_count = 0;
        end else begin
            if (i_digest.valid && i_digest.ready) begin
                got = {i_digest.digest_words_0_1, i_digest.digest_words_2_3,
                       i_digest.digest_words_4_5, i_digest.digest_words_6_7};
                if (expected_digests.size() == 0) begin
                    $display("%0t: digest transaction with none expected, got %h",
                             $time, got);
                    mismatch_count++;
                end else begin
                    want = expected_digests.pop_front();
                    for (j = 0; j < 4; j++) begin
                        if (got[255-64*j -: 64] !== want[255-64*j -: 64]) begin
                            $display("%0t: digest_words_%0d_%0d expected %h, got %h",
                                     $time, 2*j, 2*j+1, want[255-64*j -: 64],
                                     got[255-64*j -: 64]);
                            mismatch_count++;
                        end
                    end
                end
            end
            if (i_byte.valid && i_byte.ready) begin
                if (i_byte.byte_valid) begin
                    block_bytes[bytes_held] = i_byte.data_byte;
                    bytes_held = bytes_held + 6'd1;
                    length_bits = length_bits + 64'd8;
                    if (bytes_held == 6'd0) compress_block();
                end
                if (i_byte.last_byte) expected_digests.push_back(close_message());
            end
        end
        o_fail_count = mismatch_count;
        o_outstanding = expected_digests.size();
    end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Top of the SHA-256 stream hasher testbench: clock, reset and stimulus.
// Drives directed and random messages with random idling on both channels;
// depends on the RTL, its interfaces and shs_digest_checker.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1500;
    localparam int MESSAGE_TARGET = 24;
    localparam int DRAIN_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   messages_sent = 0;
    logic steady_send = 1'b0;

    shs_byte_if   byte_ch ();
    shs_digest_if digest_ch ();

    sha256_stream_hasher dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_digest (digest_ch)
    );

    shs_digest_checker digest_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (byte_ch),
        .i_digest      (digest_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sha256_stream_hasher regression: fail");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic ends);
        int unsigned gap;
        gap = steady_send ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            byte_ch.valid = 1'b0;
            byte_ch.data_byte = 8'($urandom);
            byte_ch.byte_valid = 1'($urandom);
            byte_ch.last_byte = 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid = 1'b1;
        byte_ch.data_byte = data;
        byte_ch.byte_valid = has_byte;
        byte_ch.last_byte = ends;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        if (has_byte || ends) items_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        byte_ch.valid = 1'b0;
    endtask

    task automatic send_message(input int len, input logic end_on_byte);
        int i;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (len == 0 || !end_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
        messages_sent++;
    endtask

    function automatic int pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 20);
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return $urandom_range(54, 57);
                1: return $urandom_range(62, 65);
                2: return $urandom_range(118, 121);
                default: return $urandom_range(127, 129);
            endcase
        end
        if (r < 97) return $urandom_range(21, 100);
        return $urandom_range(130, 300);
    endfunction

    initial begin
        digest_ch.ready = 1'b0;
        forever begin
            int unsigned stall_left;
            int unsigned window;
            logic steady;
            stall_left = 0;
            window = $urandom_range(50, 400);
            steady = ($urandom_range(0, 3) == 0);
            while (window != 0) begin
                @(negedge i_clk);
                window--;
                if (stall_left != 0) begin
                    digest_ch.ready = 1'b0;
                    stall_left--;
                end else begin
                    digest_ch.ready = 1'b1;
                    if (!steady) stall_left = pick_gap();
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.byte_valid = 1'b0;
        byte_ch.last_byte = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty messages, ignored transactions, "abc", single-byte extremes and a two-byte message.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'haa, 1'b1, 1'b1);
        release_input();
        wait (outstanding == 0);

        while (items_sent < ITEM_TARGET || messages_sent < MESSAGE_TARGET) begin
            steady_send = ($urandom_range(0, 3) == 0);
            send_message(pick_length(), 1'($urandom));
            if ($urandom_range(0, 9) == 0) begin
                release_input();
                wait (outstanding == 0);
            end
        end
        release_input();

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("sha256_stream_hasher regression: pass");
        end else begin
            $display("sha256_stream_hasher regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sha256_stream_hasher.f]
+incdir+rtl/core
rtl/core/shs_pkg.sv
rtl/core/shs_stream_if.sv
rtl/core/shs_msg_sched.sv
rtl/core/shs_round_core.sv
rtl/core/sha256_stream_hasher.sv
rtl/core/shs_checker.sv
tb/shs_digest_checker.sv
tb/tb_top.sv
